@@ hdl/sbck_pkg.sv @@
package sbck_pkg;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 200;
   localparam int QUEUE_DEPTH       = 4;

   // signed screen coordinate width, wide enough for a 16-bit origin plus a count
   localparam int COORD_W = 18;

   // effect flag bit positions
   localparam int FX_CENTER      = 7;
   localparam int FX_UNSUPPORTED = 6;
   localparam int FX_BEHIND      = 5;
   localparam int FX_MIRROR      = 2;
   localparam int FX_OPAQUE      = 1;

   // destination byte that behind mode may overwrite
   localparam logic [7:0] BEHIND_KEY = 8'hff;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_SKIPZERO = 2'd0,
      MODE_OPAQUE   = 2'd1,
      MODE_BEHIND   = 2'd2,
      MODE_MIRROR   = 2'd3
   } draw_mode_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_UNSUPPORTED = 2'd1,
      STATUS_NO_SPRITE   = 2'd2
   } status_type;

   // what the back end does with a classified request
   typedef enum logic [1:0] {
      KIND_PASS   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_BEHIND = 2'd2,
      KIND_READ   = 2'd3
   } back_kind_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         sprite_width;
      logic [7:0]         sprite_height;
      logic [7:0]         effects;
      logic [7:0]         pixel;
   } sbck_req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic       wrote;
      logic       sprite_done;
      logic [1:0] status;
   } sbck_rsp_type;

   typedef struct packed {
      back_kind_type kind;
      logic [7:0]    pixel;
      logic          done;
      logic [1:0]    status;
   } sbck_op_type;

endpackage

@@ hdl/sbck_req_if.sv @@
interface sbck_req_if;
   logic                   valid;
   logic                   ready;
   sbck_pkg::sbck_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sbck_rsp_if.sv @@
interface sbck_rsp_if;
   logic                   valid;
   logic                   ready;
   sbck_pkg::sbck_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sprite_blitter_color_key.sv @@
// Path: an accepted request is registered in the queue, then in the b1 and b2 stages, and
// its response in the output register. Throughput: one request per cycle while no clear
// sweep runs and rsp_bus.ready stays high; the framebuffer RAM's single read and single
// write port serve one pixel each cycle, with the behind-mode byte forwarded between them.
// Reset: synchronous, active high. It clears the sprite state and pipeline, then sweeps all
// framebuffer bytes to zero, one byte a cycle, with req_bus.ready low.
module sprite_blitter_color_key #(
   parameter int SCREEN_WIDTH  = sbck_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbck_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sbck_req_if.sink   req_bus,
   sbck_rsp_if.source rsp_bus
);
   import sbck_pkg::*;

   localparam int COL_W   = $clog2(SCREEN_WIDTH);
   localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
   localparam int ENTRY_W = $bits(sbck_op_type) + ROW_W + COL_W;

   // Front end: take a request, advance sprite position counters, decide what the
   // framebuffer must do (write, conditional write, read or nothing).
   logic               busy;
   logic               q_full;
   logic               f_push;
   sbck_op_type        f_op;
   logic [COL_W-1:0]   f_col;
   logic [ROW_W-1:0]   f_row;

   // Queue between the two halves; entries hold the decision plus the screen cell.
   logic [ENTRY_W-1:0] q_wdata;
   logic [ENTRY_W-1:0] q_rdata;
   logic               q_valid;
   logic               q_pop;

   // Back end view of the queue head
   sbck_op_type        b_op;
   logic [COL_W-1:0]   b_col;
   logic [ROW_W-1:0]   b_row;

   // Hold requests off while the clear sweep runs.
   sbck_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (busy),
      .queue_full (q_full),
      .req_bus    (req_bus),
      .push       (f_push),
      .push_op    (f_op),
      .push_col   (f_col),
      .push_row   (f_row)
   );

   assign q_wdata = {f_op, f_row, f_col};

   sbck_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rdata)
   );

   assign {b_op, b_row, b_col} = q_rdata;

   // Back end: address the framebuffer, read, resolve behind mode, write, and
   // park the response in the output register so the queue can keep draining.
   sbck_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .busy      (busy),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_op    (b_op),
      .pop_col   (b_col),
      .pop_row   (b_row),
      .rsp_bus   (rsp_bus)
   );

endmodule

@@ hdl/sbck_queue.sv @@
module sbck_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sbck_pkg::QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import sbck_pkg::*;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (PTR_W+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue pushed while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("queue popped while empty");
`endif

endmodule

@@ hdl/sbck_front.sv @@
module sbck_front #(
   parameter int SCREEN_WIDTH  = sbck_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbck_pkg::SCREEN_HEIGHT_DEF,
   localparam int COL_W = $clog2(SCREEN_WIDTH),
   localparam int ROW_W = $clog2(SCREEN_HEIGHT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  hold,
   input  logic                  queue_full,
   sbck_req_if.sink              req_bus,
   output logic                  push,
   output sbck_pkg::sbck_op_type push_op,
   output logic [COL_W-1:0]      push_col,
   output logic [ROW_W-1:0]      push_row
);
   import sbck_pkg::*;

   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] origin_y_ff, origin_y_in;
   logic [7:0]         width_ff, width_in;
   logic [7:0]         height_ff, height_in;
   draw_mode_type      mode_ff, mode_in;
   logic [7:0]         col_cnt_ff, col_cnt_in;
   logic [7:0]         row_cnt_ff, row_cnt_in;
   logic               active_ff, active_in;

   sbck_req_type       req;
   logic               accept;
   logic [COORD_W-1:0] ox_ext, oy_ext, pix_col, pix_row, col_s, row_s;
   logic               on_screen;
   logic [15:0]        begin_x, begin_y;
   logic [8:0]         col_next, row_next;

   assign req           = req_bus.data;
   assign req_bus.ready = !hold && !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept;

   assign ox_ext = {{(COORD_W-16){origin_x_ff[15]}}, origin_x_ff};
   assign oy_ext = {{(COORD_W-16){origin_y_ff[15]}}, origin_y_ff};

   // mirror draws leftward starting one column left of the origin
   assign pix_col = (mode_ff == MODE_MIRROR)
                  ? ox_ext - COORD_W'(1) - COORD_W'(col_cnt_ff)
                  : ox_ext + COORD_W'(col_cnt_ff);
   assign pix_row = oy_ext + COORD_W'(row_cnt_ff);

   assign col_s = (req.cmd == CMD_PIXEL) ? pix_col
                : {{(COORD_W-16){req.pos_x[15]}}, req.pos_x};
   assign row_s = (req.cmd == CMD_PIXEL) ? pix_row
                : {{(COORD_W-16){req.pos_y[15]}}, req.pos_y};

   assign on_screen = !col_s[COORD_W-1] && !row_s[COORD_W-1]
                   && (col_s[COORD_W-2:0] < (COORD_W-1)'(SCREEN_WIDTH))
                   && (row_s[COORD_W-2:0] < (COORD_W-1)'(SCREEN_HEIGHT));

   assign push_col = on_screen ? col_s[COL_W-1:0] : '0;
   assign push_row = on_screen ? row_s[ROW_W-1:0] : '0;

   assign begin_x = req.effects[FX_CENTER]
                  ? 16'(req.pos_x) - {9'b0, req.sprite_width[7:1]} : 16'(req.pos_x);
   assign begin_y = req.effects[FX_CENTER]
                  ? 16'(req.pos_y) - {9'b0, req.sprite_height[7:1]} : 16'(req.pos_y);

   assign col_next = {1'b0, col_cnt_ff} + 9'd1;
   assign row_next = {1'b0, row_cnt_ff} + 9'd1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      mode_in     = mode_ff;
      col_cnt_in  = col_cnt_ff;
      row_cnt_in  = row_cnt_ff;
      active_in   = active_ff;
      push_op.kind   = KIND_PASS;
      push_op.pixel  = req.pixel;
      push_op.done   = 1'b0;
      push_op.status = STATUS_OK;

      unique case (req.cmd)
         CMD_BEGIN: begin
            origin_x_in = $signed(begin_x);
            origin_y_in = $signed(begin_y);
            width_in    = req.sprite_width;
            height_in   = req.sprite_height;
            col_cnt_in  = '0;
            row_cnt_in  = '0;
            priority if (req.effects[FX_MIRROR]) begin
               mode_in = MODE_MIRROR;
            end else if (req.effects[FX_OPAQUE]) begin
               mode_in = MODE_OPAQUE;
            end else if (req.effects[FX_BEHIND]) begin
               mode_in = MODE_BEHIND;
            end else begin
               mode_in = MODE_SKIPZERO;
            end
            priority if (req.effects[FX_UNSUPPORTED]) begin
               push_op.status = STATUS_UNSUPPORTED;
               active_in      = 1'b0;
            end else if (req.sprite_width == '0 || req.sprite_height == '0) begin
               push_op.done = 1'b1;
               active_in    = 1'b0;
            end else begin
               active_in = 1'b1;
            end
         end
         CMD_PIXEL: begin
            if (!active_ff) begin
               push_op.status = STATUS_NO_SPRITE;
            end else begin
               if (on_screen) begin
                  unique case (mode_ff)
                     MODE_OPAQUE: push_op.kind = KIND_WRITE;
                     MODE_BEHIND: push_op.kind = KIND_BEHIND;
                     MODE_SKIPZERO, MODE_MIRROR: begin
                        push_op.kind = (req.pixel != '0) ? KIND_WRITE : KIND_PASS;
                     end
                  endcase
               end
               if (col_next >= {1'b0, width_ff}) begin
                  col_cnt_in = '0;
                  if (row_next >= {1'b0, height_ff}) begin
                     row_cnt_in   = '0;
                     active_in    = 1'b0;
                     push_op.done = 1'b1;
                  end else begin
                     row_cnt_in = row_next[7:0];
                  end
               end else begin
                  col_cnt_in = col_next[7:0];
               end
            end
         end
         CMD_READ: begin
            if (on_screen) begin
               push_op.kind = KIND_READ;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         mode_ff     <= MODE_SKIPZERO;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         active_ff   <= 1'b0;
      end else if (accept) begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         mode_ff     <= mode_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         active_ff   <= active_in;
      end
   end

endmodule

@@ hdl/sbck_back.sv @@
module sbck_back #(
   parameter int SCREEN_WIDTH  = sbck_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbck_pkg::SCREEN_HEIGHT_DEF,
   localparam int COL_W  = $clog2(SCREEN_WIDTH),
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT),
   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  busy,
   input  logic                  pop_valid,
   output logic                  pop,
   input  sbck_pkg::sbck_op_type pop_op,
   input  logic [COL_W-1:0]      pop_col,
   input  logic [ROW_W-1:0]      pop_row,
   sbck_rsp_if.source            rsp_bus
);
   import sbck_pkg::*;

   logic [7:0] frame_mem [DEPTH];

   logic              busy_ff;
   logic [ADDR_W-1:0] clear_addr_ff;

   logic              b1_valid_ff;
   sbck_op_type       b1_op_ff;
   logic [ADDR_W-1:0] b1_addr_ff;

   logic              b2_valid_ff;
   sbck_op_type       b2_op_ff;
   logic [ADDR_W-1:0] b2_addr_ff;
   logic              b2_fwd_ff;
   logic [7:0]        b2_fwd_data_ff;
   logic [7:0]        rd_data_ff;

   logic              rsp_valid_ff;
   sbck_rsp_type      rsp_data_ff, rsp_in;

   logic              advance1, advance2, b1_free, b2_free;
   logic [ADDR_W-1:0] pop_addr;
   logic [7:0]        mem_val;
   logic              write_cond, b2_wr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [7:0]        mem_wd;

   assign busy = busy_ff;

   // stall chain from the response register backward
   assign advance2 = b2_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign b2_free  = !b2_valid_ff || advance2;
   assign advance1 = b1_valid_ff && b2_free;
   assign b1_free  = !b1_valid_ff || advance1;
   assign pop      = pop_valid && b1_free;

   assign pop_addr = ADDR_W'(pop_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pop_col);

   assign mem_val = b2_fwd_ff ? b2_fwd_data_ff : rd_data_ff;

   always_comb begin
      write_cond            = 1'b0;
      rsp_in.read_value     = '0;
      rsp_in.sprite_done    = b2_op_ff.done;
      rsp_in.status         = b2_op_ff.status;
      unique case (b2_op_ff.kind)
         KIND_PASS:   write_cond = 1'b0;
         KIND_WRITE:  write_cond = 1'b1;
         KIND_BEHIND: write_cond = (mem_val == BEHIND_KEY);
         KIND_READ:   rsp_in.read_value = mem_val;
      endcase
      rsp_in.wrote = write_cond;
   end

   assign b2_wr  = advance2 && write_cond;
   assign mem_we = busy_ff || b2_wr;
   assign mem_wa = busy_ff ? clear_addr_ff : b2_addr_ff;
   assign mem_wd = busy_ff ? 8'h00 : b2_op_ff.pixel;

   // clearing sweep after reset, one byte a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         clear_addr_ff <= '0;
      end else if (busy_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      if (advance1) begin
         rd_data_ff <= frame_mem[b1_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b2_fwd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b1_free) begin
            b1_valid_ff <= pop;
         end
         if (b2_free) begin
            b2_valid_ff <= advance1;
            // the byte read this edge misses a write to the same address this edge
            b2_fwd_ff   <= advance1 && b2_wr && (b2_addr_ff == b1_addr_ff);
         end
         if (advance2) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_op_ff   <= pop_op;
         b1_addr_ff <= pop_addr;
      end
      if (advance1) begin
         b2_op_ff       <= b1_op_ff;
         b2_addr_ff     <= b1_addr_ff;
         b2_fwd_data_ff <= b2_op_ff.pixel;
      end
      if (advance2) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !b1_valid_ff && !b2_valid_ff)
      else $error("request in flight during framebuffer clear");
   a_no_write_contention: assert property (@(posedge clock) disable iff (reset)
      b2_wr |-> !busy_ff)
      else $error("pixel write collides with clear sweep");
   a_forward_has_owner: assert property (@(posedge clock) disable iff (reset)
      b2_fwd_ff |-> b2_valid_ff)
      else $error("forwarded byte without a request in the read stage");
`endif

endmodule

@@ tb/sbck_frame_checker.sv @@
module sbck_frame_checker #(
   parameter int SCREEN_WIDTH  = sbck_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = sbck_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic clock,
   input  logic reset,
   sbck_req_if  req_mon,
   sbck_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);
   import sbck_pkg::*;

   localparam int PRINT_CAP = 50;

   // shadow framebuffer and sprite state
   logic [7:0]         frame_img [SCREEN_WIDTH*SCREEN_HEIGHT];
   logic signed [15:0] org_x, org_y;
   logic [7:0]         spr_w, spr_h;
   int                 col_idx, row_idx;
   draw_mode_type      blit_mode;
   logic               sprite_live;

   sbck_rsp_type       rsp_expected [$];

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic on_screen(input int col, input int row);
      return col >= 0 && row >= 0 && col < SCREEN_WIDTH && row < SCREEN_HEIGHT;
   endfunction

   function automatic sbck_rsp_type blit_predict(input sbck_req_type r);
      sbck_rsp_type o;
      int           col, row, addr;
      logic         put;
      o = '0;
      case (r.cmd)
         CMD_BEGIN: begin
            sprite_live = 1'b0;
            col_idx     = 0;
            row_idx     = 0;
            spr_w       = r.sprite_width;
            spr_h       = r.sprite_height;
            org_x       = r.pos_x;
            org_y       = r.pos_y;
            // center: subtract half the size, wrapping in 16 bits
            if (r.effects[FX_CENTER]) begin
               org_x = r.pos_x - 16'(r.sprite_width >> 1);
               org_y = r.pos_y - 16'(r.sprite_height >> 1);
            end
            if (r.effects[FX_MIRROR])      blit_mode = MODE_MIRROR;
            else if (r.effects[FX_OPAQUE]) blit_mode = MODE_OPAQUE;
            else if (r.effects[FX_BEHIND]) blit_mode = MODE_BEHIND;
            else                           blit_mode = MODE_SKIPZERO;
            if (r.effects[FX_UNSUPPORTED])      o.status = STATUS_UNSUPPORTED;
            else if (spr_w == 0 || spr_h == 0)  o.sprite_done = 1'b1;
            else                                sprite_live = 1'b1;
         end
         CMD_PIXEL: begin
            if (!sprite_live) begin
               o.status = STATUS_NO_SPRITE;
            end else begin
               row = int'(org_y) + row_idx;
               if (blit_mode == MODE_MIRROR) col = int'(org_x) - 1 - col_idx;
               else                          col = int'(org_x) + col_idx;
               if (on_screen(col, row)) begin
                  addr = row * SCREEN_WIDTH + col;
                  case (blit_mode)
                     MODE_OPAQUE: put = 1'b1;
                     MODE_BEHIND: put = (frame_img[addr] == BEHIND_KEY);
                     default:     put = (r.pixel != 8'h00);
                  endcase
                  if (put) begin
                     frame_img[addr] = r.pixel;
                     o.wrote         = 1'b1;
                  end
               end
               // off-screen pixels still advance the counts
               col_idx++;
               if (col_idx >= int'(spr_w)) begin
                  col_idx = 0;
                  row_idx++;
                  if (row_idx >= int'(spr_h)) begin
                     row_idx       = 0;
                     sprite_live   = 1'b0;
                     o.sprite_done = 1'b1;
                  end
               end
            end
         end
         CMD_READ: begin
            col = int'($signed(r.pos_x));
            row = int'($signed(r.pos_y));
            if (on_screen(col, row))
               o.read_value = frame_img[row * SCREEN_WIDTH + col];
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      sbck_rsp_type want, got;
      if (reset) begin
         foreach (frame_img[a]) frame_img[a] = 8'h00;
         org_x       = '0;
         org_y       = '0;
         spr_w       = '0;
         spr_h       = '0;
         col_idx     = 0;
         row_idx     = 0;
         blit_mode   = MODE_SKIPZERO;
         sprite_live = 1'b0;
         rsp_expected.delete();
      end else begin
         // retire first so a stray response never consumes this cycle's request
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (rsp_expected.size() == 0) begin
               report_mismatch($sformatf("response %p with no request outstanding", got));
            end else begin
               want = rsp_expected.pop_front();
               if (got.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value expected %02h got %02h",
                                            want.read_value, got.read_value));
               if (got.wrote !== want.wrote)
                  report_mismatch($sformatf("wrote expected %b got %b",
                                            want.wrote, got.wrote));
               if (got.sprite_done !== want.sprite_done)
                  report_mismatch($sformatf("sprite_done expected %b got %b",
                                            want.sprite_done, got.sprite_done));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status expected %0d got %0d",
                                            want.status, got.status));
            end
         end
         if (req_mon.valid && req_mon.ready)
            rsp_expected.push_back(blit_predict(req_mon.data));
      end
      pending_count <= rsp_expected.size();
   end

endmodule

@@ tb/tb_sprite_blitter_color_key.sv @@
module tb_sprite_blitter_color_key;
   import sbck_pkg::*;

   localparam int SCREEN_W        = SCREEN_WIDTH_DEF;
   localparam int SCREEN_H        = SCREEN_HEIGHT_DEF;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int IDLE_PERCENT    = 29;
   // quiet-cycle limit: must ride out the post-reset framebuffer sweep with room to spare
   localparam int QUIET_LIMIT     = 4 * SCREEN_W * SCREEN_H;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STEADY_FROM     = 600;
   localparam int STEADY_TO       = 900;
   localparam int RESET_CYCLES    = 11;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [7:0] FX_NONE    = 8'h00;
   localparam logic [7:0] FX_ALL     = 8'hff;

   logic clock;
   logic reset;
   logic idle_on;
   int   sent_count;
   int   quiet_cycles;
   int   mismatches;
   int   pending;
   int   random_base;

   sbck_req_if req_bus ();
   sbck_rsp_if rsp_bus ();

   sprite_blitter_color_key #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sbck_frame_checker #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H)
   ) frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response side at random unless a steady stretch is running.
   always @(posedge clock) begin
      if (idle_on) rsp_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      else         rsp_bus.ready <= 1'b1;
   end

   // Watchdog: count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one request, idling first at random; return at the accepting edge.
   // Valid stays high into the next request, so back-to-back requests need no gap.
   task automatic push_request(input sbck_req_type item);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   // Fill every field with noise; the block must ignore fields the command does not use.
   function automatic sbck_req_type scrambled_request();
      sbck_req_type item;
      item.cmd           = CMD_READ;
      item.pos_x         = 16'($urandom);
      item.pos_y         = 16'($urandom);
      item.sprite_width  = 8'($urandom);
      item.sprite_height = 8'($urandom);
      item.effects       = 8'($urandom);
      item.pixel         = 8'($urandom);
      return item;
   endfunction

   task automatic send_begin(input int x, input int y, input int w, input int h,
                             input logic [7:0] fx);
      sbck_req_type item;
      item               = scrambled_request();
      item.cmd           = CMD_BEGIN;
      item.pos_x         = 16'(x);
      item.pos_y         = 16'(y);
      item.sprite_width  = 8'(w);
      item.sprite_height = 8'(h);
      item.effects       = fx;
      push_request(item);
   endtask

   task automatic send_pixel(input logic [7:0] value);
      sbck_req_type item;
      item       = scrambled_request();
      item.cmd   = CMD_PIXEL;
      item.pixel = value;
      push_request(item);
   endtask

   task automatic send_read(input int x, input int y);
      sbck_req_type item;
      item       = scrambled_request();
      item.cmd   = CMD_READ;
      item.pos_x = 16'(x);
      item.pos_y = 16'(y);
      push_request(item);
   endtask

   task automatic send_unused();
      sbck_req_type item;
      item     = scrambled_request();
      item.cmd = CMD_UNUSED;
      push_request(item);
   endtask

   // Bias pixels toward zero (transparent) and 0xff (behind-mode key).
   function automatic logic [7:0] rand_pixel();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25)      return 8'h00;
      else if (pick < 50) return BEHIND_KEY;
      else                return 8'($urandom);
   endfunction

   // Cluster many sprites in a small corner so they overlap, spread others over the
   // screen, keep some on the screen edges and a few anywhere in the 16-bit range.
   function automatic int rand_coord(input int extent);
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)      return int'($urandom_range(23));
      else if (pick < 75) return int'($urandom_range(extent - 1));
      else if (pick < 85) return int'($urandom_range(16)) - 10;
      else if (pick < 95) return extent - 6 + int'($urandom_range(16));
      else                return int'($signed(16'($urandom)));
   endfunction

   // One sprite with random placement, mode and content, with reads around it.
   task automatic draw_random_sprite();
      int          pick, w, h, x, y, total, stop_at;
      logic [7:0]  fx;
      pick = $urandom_range(199);
      if (pick == 0) begin
         w = 255;
         h = 1;
      end else if (pick == 1) begin
         w = 1;
         h = 255;
      end else if (pick < 5) begin
         w = 0;
         h = $urandom_range(255);
      end else if (pick < 8) begin
         w = $urandom_range(255);
         h = 0;
      end else if (pick < 24) begin
         w = $urandom_range(1, 24);
         h = $urandom_range(1, 12);
      end else begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 6);
      end
      x = rand_coord(SCREEN_W);
      y = rand_coord(SCREEN_H);

      // pick the mode explicitly, then scatter the lower-priority flags
      fx                 = 8'($urandom);
      fx[FX_MIRROR]      = 1'b0;
      fx[FX_OPAQUE]      = 1'b0;
      fx[FX_BEHIND]      = 1'b0;
      if ($urandom_range(19) != 0) fx[FX_UNSUPPORTED] = 1'b0;
      case ($urandom_range(3))
         0: ;
         1: begin
            fx[FX_OPAQUE] = 1'b1;
            fx[FX_BEHIND] = 1'($urandom);
         end
         2: fx[FX_BEHIND] = 1'b1;
         default: begin
            fx[FX_MIRROR] = 1'b1;
            fx[FX_OPAQUE] = 1'($urandom);
            fx[FX_BEHIND] = 1'($urandom);
         end
      endcase
      send_begin(x, y, w, h, fx);

      total = w * h;
      // abandon a few sprites part way; keep stray bursts after a refusal short
      if (fx[FX_UNSUPPORTED])          stop_at = (total < 3) ? total : 3;
      else if ($urandom_range(19) == 0) stop_at = $urandom_range(total);
      else                             stop_at = total;
      for (int i = 0; i < stop_at; i++) begin
         if ($urandom_range(9) == 0)
            send_read(x + int'($urandom_range(2 * w + 4)) - w - 2,
                      y + int'($urandom_range(2 * h + 2)) - h - 1);
         send_pixel(rand_pixel());
      end

      // probe the area just drawn
      repeat ($urandom_range(1, 3))
         send_read(x + int'($urandom_range(2 * w + 4)) - w - 2,
                   y + int'($urandom_range(2 * h + 2)) - h - 1);
      if ($urandom_range(9) == 0)  send_pixel(rand_pixel());
      if ($urandom_range(29) == 0) send_unused();
   endtask

   initial begin
      reset         = 1'b1;
      idle_on       = 1'b1;
      sent_count    = 0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: the framebuffer must read back clear after reset.
      send_read(0, 0);
      // pixel with no sprite open
      send_pixel(8'h5a);
      // empty areas finish at once
      send_begin(10, 10, 0, 5, FX_NONE);
      send_begin(10, 10, 5, 0, FX_NONE);
      // unsupported flag refuses the sprite; the next pixel is a stray
      send_begin(0, 0, 4, 4, 8'h40);
      send_pixel(8'h11);
      // opaque 2x2 on the bottom-right corner: one byte lands, three fall off screen
      send_begin(SCREEN_W - 1, SCREEN_H - 1, 2, 2, 8'h02);
      send_pixel(BEHIND_KEY);
      send_pixel(8'h00);
      send_pixel(8'h33);
      send_pixel(8'h44);
      // behind mode writes only over the key byte
      send_begin(SCREEN_W - 2, SCREEN_H - 1, 2, 1, 8'h20);
      send_pixel(8'h66);
      send_pixel(8'h77);
      send_read(SCREEN_W - 1, SCREEN_H - 1);
      // centered mirror: lands left of the origin, zero pixel skipped
      send_begin(3, 0, 2, 1, 8'h84);
      send_pixel(8'h80);
      send_pixel(8'h00);
      send_read(1, 0);
      // extreme origin wraps when centered; abandon it after one pixel
      send_begin(-32768, 32767, 255, 255, 8'h81);
      send_pixel(BEHIND_KEY);
      send_begin(32767, -32768, 1, 1, FX_ALL);
      // off-screen reads return zero
      send_read(-1, 0);
      send_read(32767, -32768);
      send_read(SCREEN_W, 0);
      send_unused();

      // Random: mostly complete sprites, with a stretch where neither side idles.
      random_base = sent_count;
      while (sent_count < random_base + RANDOM_REQUESTS) begin
         idle_on <= !(sent_count >= random_base + STEADY_FROM &&
                      sent_count <  random_base + STEADY_TO);
         draw_random_sprite();
      end

      // Drop valid, let the checker register the last request, then drain.
      req_bus.valid <= 1'b0;
      idle_on       <= 1'b1;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/sbck_pkg.sv
hdl/sbck_req_if.sv
hdl/sbck_rsp_if.sv
hdl/sbck_queue.sv
hdl/sbck_front.sv
hdl/sbck_back.sv
hdl/sprite_blitter_color_key.sv
tb/sbck_frame_checker.sv
tb/tb_sprite_blitter_color_key.sv
